// File: hw/rtl/assert_macros.svh
// assertion macros for the rtl modules, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, sampled on clk_i, off during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/mfps_pkg.sv
// package for the minimum falling path sum block: widths, register indexes, types
`timescale 1ns / 1ps
package mfps_pkg;

  // row buffer depth and derived widths
  localparam int MAX_COLS = 1024;
  localparam int ADDR_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W    = $clog2(MAX_COLS + 1);

  // fixed field widths
  localparam int CELL_W   = 32;
  localparam int COST_W   = 48;
  localparam int BCOL_W   = 10;
  localparam int ROWCNT_W = 15;
  localparam int COLCNT_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1
  } cfg_reg_e;

  // one cell in the compute stage
  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic [ADDR_W-1:0] col;
    logic              first_row;
    logic              has_left;
    logic              has_right;
    logic              last_row;
    logic              last_col;
    logic              emit;
    logic              fwd_a;
    logic              fwd_b;
  } s1_t;

endpackage

// File: hw/rtl/mfps_ram.sv
// generic ram: one write port, two registered read ports, read-first
`timescale 1ns / 1ps
module mfps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // storage write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads, old data on a same-edge write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdata_a_q <= '0;
      rdata_b_q <= '0;
    end else if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: hw/rtl/min_falling_path_sum.sv
// top level: streaming minimum falling path sum over a row-major grid
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------
//  in      | input     | in_valid_i / in_stall_o  | cell_value_i
//  out     | output    | out_valid_o / out_stall_i| best_cost_o, best_column_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// one cell per cycle sustained while in_stall_o is low; a request is taken together with its
// row ram read into the compute stage, and a grid result goes from there to the output register
// the rate is set by the row ram: two reads and one write each cycle
// reset clears counters, running minimum and pipeline; the row ram is not cleared
// in_stall_o rises only when a grid result waits in the output register while
// out_stall_i is high and the compute stage holds the next grid result
`timescale 1ns / 1ps
`include "assert_macros.svh"
module min_falling_path_sum (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [mfps_pkg::CELL_W-1:0] cell_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [mfps_pkg::COST_W-1:0] best_cost_o,
  output logic [mfps_pkg::BCOL_W-1:0]        best_column_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mfps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mfps_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import mfps_pkg::*;

  // configuration registers
  logic [ROWCNT_W-1:0] row_cnt_q;
  logic [COLCNT_W-1:0] col_cnt_q;

  // grid position
  logic [ROWCNT_W-1:0] row_idx_q, row_idx_d;
  logic [ADDR_W-1:0]   col_idx_q, col_idx_d;

  // compute stage
  logic s1_valid_q, s1_valid_d;
  s1_t  s1_q, s1_d;
  logic s1_fire;
  logic in_accept;

  // window, forwarding and running minimum
  logic signed [COST_W-1:0] win_left_q, win_left_d;
  logic signed [COST_W-1:0] fwd_data_q;
  logic signed [COST_W-1:0] run_cost_q, run_cost_d;
  logic [ADDR_W-1:0]        run_col_q, run_col_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic signed [COST_W-1:0] best_cost_q;
  logic [BCOL_W-1:0]        best_col_q;

  // ram ports
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic [COST_W-1:0] rd_data_a, rd_data_b;

  // live counts and position decode
  logic [CNT_W-1:0]    cols_live;
  logic [ROWCNT_W-1:0] rows_live;
  logic [ADDR_W-1:0]   col_j;
  logic                dec_last_col, dec_last_row, dec_has_right;

  // datapath of the compute stage
  logic signed [COST_W-1:0] mid_cost, right_raw, left_cost, right_cost;
  logic signed [COST_W-1:0] best_lm, best_all, cell_ext, cell_cost;
  logic                     min_upd;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= ROWCNT_W'(1);
      col_cnt_q <= COLCNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROW_COUNT:    row_cnt_q <= cfg_data_i[ROWCNT_W-1:0];
        REG_COLUMN_COUNT: col_cnt_q <= cfg_data_i[COLCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts act as one, columns saturate at the row buffer depth
  always_comb begin
    if (col_cnt_q == '0) begin
      cols_live = CNT_W'(1);
    end else if (32'(col_cnt_q) > MAX_COLS) begin
      cols_live = CNT_W'(MAX_COLS);
    end else begin
      cols_live = CNT_W'(col_cnt_q);
    end
    rows_live = (row_cnt_q == '0) ? ROWCNT_W'(1) : row_cnt_q;
  end

  // position decode for the incoming cell
  always_comb begin
    if (CNT_W'(col_idx_q) >= cols_live) begin
      col_j = ADDR_W'(cols_live - CNT_W'(1));
    end else begin
      col_j = col_idx_q;
    end
    dec_last_col  = (CNT_W'(col_idx_q) + CNT_W'(1)) >= cols_live;
    dec_last_row  = ({1'b0, row_idx_q} + (ROWCNT_W + 1)'(1)) >= {1'b0, rows_live};
    dec_has_right = (CNT_W'(col_j) + CNT_W'(1)) < cols_live;
    rd_addr_a     = col_j;
    rd_addr_b     = dec_has_right ? ADDR_W'(CNT_W'(col_j) + CNT_W'(1)) : col_j;
  end

  // handshake
  assign s1_fire    = s1_valid_q && !(s1_q.emit && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // load of the compute stage and position update
  always_comb begin
    s1_d       = s1_q;
    s1_valid_d = s1_valid_q;
    row_idx_d  = row_idx_q;
    col_idx_d  = col_idx_q;
    if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    if (in_accept) begin
      s1_valid_d     = 1'b1;
      s1_d.cell_val  = cell_value_i;
      s1_d.col       = col_j;
      s1_d.first_row = (row_idx_q == '0);
      s1_d.has_left  = (col_j != '0);
      s1_d.has_right = dec_has_right;
      s1_d.last_row  = dec_last_row;
      s1_d.last_col  = dec_last_col;
      s1_d.emit      = dec_last_row && dec_last_col;
      // the write leaving the compute stage on this edge is not yet in the ram
      s1_d.fwd_a     = s1_fire && (s1_q.col == rd_addr_a);
      s1_d.fwd_b     = s1_fire && (s1_q.col == rd_addr_b);
      if (dec_last_col) begin
        col_idx_d = '0;
        row_idx_d = dec_last_row ? '0 : row_idx_q + ROWCNT_W'(1);
      end else begin
        col_idx_d = col_idx_q + ADDR_W'(1);
      end
    end
  end

  // three-way window minimum and add (first row takes the cell alone), leftmost wins on a tie
  always_comb begin
    mid_cost   = s1_q.fwd_a ? fwd_data_q : $signed(rd_data_a);
    right_raw  = s1_q.fwd_b ? fwd_data_q : $signed(rd_data_b);
    left_cost  = s1_q.has_left ? win_left_q : mid_cost;
    right_cost = s1_q.has_right ? right_raw : mid_cost;
    best_lm    = (mid_cost < left_cost) ? mid_cost : left_cost;
    best_all   = (right_cost < best_lm) ? right_cost : best_lm;
    cell_ext   = COST_W'($signed(s1_q.cell_val));
    cell_cost  = s1_q.first_row ? cell_ext : best_all + cell_ext;
  end

  // window, running minimum and output register next state
  always_comb begin
    win_left_d  = win_left_q;
    run_cost_d  = run_cost_q;
    run_col_d   = run_col_q;
    out_valid_d = out_valid_q && out_stall_i;
    min_upd     = s1_q.last_row && ((s1_q.col == '0) || (cell_cost < run_cost_q));
    if (s1_fire) begin
      win_left_d = s1_q.last_col ? '0 : mid_cost;
      if (min_upd) begin
        run_cost_d = cell_cost;
        run_col_d  = s1_q.col;
      end
      if (s1_q.emit) begin
        out_valid_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_idx_q   <= '0;
      col_idx_q   <= '0;
      s1_valid_q  <= 1'b0;
      s1_q        <= '0;
      win_left_q  <= '0;
      run_cost_q  <= '0;
      run_col_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      row_idx_q   <= row_idx_d;
      col_idx_q   <= col_idx_d;
      s1_valid_q  <= s1_valid_d;
      s1_q        <= s1_d;
      win_left_q  <= win_left_d;
      out_valid_q <= out_valid_d;
      if (s1_fire && s1_q.emit) begin
        run_cost_q <= '0;
        run_col_q  <= '0;
      end else begin
        run_cost_q <= run_cost_d;
        run_col_q  <= run_col_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      fwd_data_q <= cell_cost;
    end
    if (s1_fire && s1_q.emit) begin
      best_cost_q <= run_cost_d;
      best_col_q  <= BCOL_W'(run_col_d);
    end
  end

  // previous-row cost buffer
  mfps_ram #(
    .WIDTH (COST_W),
    .DEPTH (MAX_COLS),
    .AW    (ADDR_W)
  ) u_row_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (s1_fire),
    .waddr_i   (s1_q.col),
    .wdata_i   (cell_cost),
    .re_i      (in_accept),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (rd_data_a),
    .rdata_b_o (rd_data_b)
  );

  assign out_valid_o   = out_valid_q;
  assign best_cost_o   = best_cost_q;
  assign best_column_o = best_col_q;

  // checks
  `ASSERT_NEXT(a_accept_fills_stage, in_accept, s1_valid_q)
  `ASSERT_IMPL(a_out_from_emit, $rose(out_valid_q), $past(s1_fire && s1_q.emit))
  `ASSERT_IMPL(a_no_overrun, out_valid_q && out_stall_i && s1_valid_q && s1_q.emit, in_stall_o)
  `ASSERT_IMPL(a_emit_ends_row, s1_valid_q && s1_q.emit, s1_q.last_col && s1_q.last_row)

endmodule

// File: dv/tb_min_falling_path_sum.sv
// testbench for the streaming minimum falling path sum block
`timescale 1ns / 1ps
module tb_min_falling_path_sum;
  import mfps_pkg::*;

  // spare register index, not decoded by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

  localparam logic signed [CELL_W-1:0] CELL_MIN = 32'sh8000_0000;
  localparam logic signed [CELL_W-1:0] CELL_MAX = 32'sh7FFF_FFFF;

  // one grid result
  typedef struct packed {
    logic signed [COST_W-1:0] cost;
    logic [BCOL_W-1:0]        column;
  } grid_min_t;

  // dut ports
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [CELL_W-1:0] cell_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [COST_W-1:0] best_cost_o;
  logic [BCOL_W-1:0]        best_column_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i = '0;

  // predicted path state
  logic signed [COST_W-1:0] prev_row_cost [MAX_COLS];
  logic signed [COST_W-1:0] left_prev_cost = '0;
  int unsigned              grid_row = 0;
  int unsigned              grid_col = 0;
  logic signed [COST_W-1:0] row_min_cost = '0;
  int unsigned              row_min_col = 0;
  int unsigned              rows_setting = 1;
  int unsigned              cols_setting = 1;

  grid_min_t   pending_minima [$];
  grid_min_t   oldest_min;
  int unsigned mismatch_count = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  int unsigned stall_left = 0;

  min_falling_path_sum dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cell_value_i  (cell_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .best_cost_o   (best_cost_o),
    .best_column_o (best_column_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap(input bit idle_on);
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(12, 40);
  endfunction

  // cell value biased toward extremes and small ties
  function automatic logic signed [CELL_W-1:0] pick_cell();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return CELL_MIN;
    if (r == 1) return CELL_MAX;
    if (r < 5) return CELL_W'($urandom_range(0, 16)) - CELL_W'(8);
    return CELL_W'($urandom);
  endfunction

  // advance the path costs by one cell, queue the grid minimum at the end
  task automatic advance_path_costs(input logic signed [CELL_W-1:0] cell_val);
    int unsigned              rows;
    int unsigned              cols;
    int unsigned              j;
    logic signed [COST_W-1:0] cost;
    logic signed [COST_W-1:0] mid;
    logic signed [COST_W-1:0] left;
    logic signed [COST_W-1:0] right;
    logic signed [COST_W-1:0] best;
    bit                       last_row;
    bit                       last_col;
    grid_min_t                res;
    rows = (rows_setting == 0) ? 1 : rows_setting;
    cols = (cols_setting == 0) ? 1 : cols_setting;
    if (cols > MAX_COLS) cols = MAX_COLS;
    j = (grid_col >= cols) ? cols - 1 : grid_col;
    if (grid_row == 0) begin
      cost = cell_val;
    end else begin
      mid   = prev_row_cost[j];
      left  = (j > 0) ? left_prev_cost : mid;
      right = (j + 1 < cols) ? prev_row_cost[j + 1] : mid;
      best  = (mid < left) ? mid : left;
      if (right < best) best = right;
      cost = best + cell_val;
    end
    left_prev_cost   = prev_row_cost[j];
    prev_row_cost[j] = cost;
    last_row = (grid_row + 1 >= rows);
    last_col = (grid_col + 1 >= cols);
    if (last_row && (j == 0 || cost < row_min_cost)) begin
      row_min_cost = cost;
      row_min_col  = j;
    end
    if (!last_col) begin
      grid_col++;
    end else begin
      grid_col       = 0;
      left_prev_cost = '0;
      if (!last_row) begin
        grid_row++;
      end else begin
        res.cost   = row_min_cost;
        res.column = row_min_col[BCOL_W-1:0];
        pending_minima.push_back(res);
        grid_row     = 0;
        row_min_cost = '0;
        row_min_col  = 0;
      end
    end
  endtask

  // send one cell request, predict once it is taken
  task automatic send_cell(input logic signed [CELL_W-1:0] cell_val);
    int unsigned gap;
    gap = pick_gap(in_idle_on);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i   <= 1'b0;
      cell_value_i <= CELL_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cell_value_i <= cell_val;
    do @(posedge clk_i); while (in_stall_o);
    advance_path_costs(cell_val);
  endtask

  // drop valid after the last request of a phase
  task automatic end_cells();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // wait until every grid result is back and the pipe has drained
  task automatic wait_idle();
    while (pending_minima.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // one register write through the config channel
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_ROW_COUNT) rows_setting = data[ROWCNT_W-1:0];
    else if (idx == REG_COLUMN_COUNT) cols_setting = data[COLCNT_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_grid_size(input logic [CFG_DATA_W-1:0] rows,
                               input logic [CFG_DATA_W-1:0] cols);
    end_cells();
    wait_idle();
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COLUMN_COUNT, cols);
  endtask

  // small hand-built grids: field extremes, zero counts, ties, edge clamping
  task automatic test_directed();
    logic signed [CELL_W-1:0] tie_grid [9];
    logic signed [CELL_W-1:0] edge_grid [8];
    tie_grid  = '{32'sd5, 32'sd5, 32'sd5, 32'sd1, 32'sd2, 32'sd1, 32'sd0, 32'sd0, 32'sd0};
    edge_grid = '{32'sd9, 32'sd9, 32'sd9, -32'sd3, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
    // reset size is one by one
    send_cell(CELL_MAX);
    send_cell(CELL_MIN);
    // zero counts act as one
    set_grid_size(15'd0, 15'd0);
    send_cell(32'sd0);
    // ties in the windows and in the last row, leftmost wins
    set_grid_size(15'd3, 15'd3);
    foreach (tie_grid[i]) send_cell(tie_grid[i]);
    // right edge clamped window, minimum off column zero
    set_grid_size(15'd2, 15'd4);
    foreach (edge_grid[i]) send_cell(edge_grid[i]);
    // spare index must leave the sizes alone
    end_cells();
    wait_idle();
    write_reg(REG_ROW_COUNT, 15'd1);
    write_reg(REG_COLUMN_COUNT, 15'd3);
    write_reg(REG_SPARE, 15'h7FFF);
    send_cell(CELL_MIN);
    send_cell(CELL_MAX);
    send_cell(CELL_MIN);
  endtask

  // random small grids with random content and idle patterns
  task automatic test_random_grids();
    int unsigned sent;
    int unsigned rows;
    int unsigned cols;
    int unsigned rows_reg;
    int unsigned cols_reg;
    sent = 0;
    rows = 1;
    cols = 1;
    while (sent < 330) begin
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      if (sent == 0 || $urandom_range(0, 4) != 0) begin
        rows = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        cols = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        rows_reg = (rows == 1 && $urandom_range(0, 1) == 1) ? 0 : rows;
        cols_reg = (cols == 1 && $urandom_range(0, 1) == 1) ? 0 : cols;
        // upper data bits of the column write are not part of the register
        set_grid_size(CFG_DATA_W'(rows_reg),
                      {4'($urandom_range(0, 15)), COLCNT_W'(cols_reg)});
      end
      repeat (rows * cols) begin
        send_cell(pick_cell());
        sent++;
      end
    end
  endtask

  // taller and wider grids with extreme values
  task automatic test_extreme_sizes();
    int unsigned i;
    // tall grid, all minimum cells
    in_idle_on  = 1'b0;
    out_idle_on = 1'b1;
    set_grid_size(15'd40, 15'd1);
    repeat (40) send_cell(CELL_MIN);
    // wide grid, minimum lands on the last column
    in_idle_on = 1'b1;
    set_grid_size(15'd2, 15'd48);
    repeat (48) send_cell(32'sd0);
    for (i = 0; i < 48; i++) send_cell((i == 47) ? -32'sd5 : 32'sd1000);
    // wide grid, one row, top values
    set_grid_size(15'd1, 15'd48);
    repeat (48) send_cell(($urandom_range(0, 1) == 1) ? CELL_MAX : pick_cell());
    end_cells();
  endtask

  // output stall: random gaps, most short
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap(out_idle_on);
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_minima.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: cost %0d column %0d", best_cost_o, best_column_o);
      end else begin
        oldest_min = pending_minima.pop_front();
        if (best_cost_o !== oldest_min.cost || best_column_o !== oldest_min.column) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected cost %0d column %0d, got cost %0d column %0d",
                     oldest_min.cost, oldest_min.column, best_cost_o, best_column_o);
        end
      end
    end
  end

  // run limit
  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // main sequence
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_grids();
    test_extreme_sizes();
    while (pending_minima.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
